// File: rtl/core/nft_pkg.sv
// shared types and constants for the nat flow translator
// no dependencies
package nft_pkg;

	localparam int unsigned TABLE_ENTRIES = 1024;
	localparam int unsigned AW = $clog2(TABLE_ENTRIES);
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

	localparam logic [31:0] WAN_IP_RESET = 32'hC0A8_0301;
	localparam logic [15:0] MIN_TRANSPORT_LEN = 16'd8;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [7:0] PROTO_DCCP = 8'd33;

	// register addresses (byte)
	localparam logic [4:0] ADDR_WAN_IP = 5'd0;
	localparam logic [4:0] ADDR_IN_PASS = 5'd4;
	localparam logic [4:0] ADDR_IN_PORT = 5'd8;
	localparam logic [4:0] ADDR_OUT_PASS = 5'd12;
	localparam logic [4:0] ADDR_OUT_PORT = 5'd16;

	typedef enum logic [2:0] {
		V_TRANSLATED = 3'd0,
		V_PASSED = 3'd1,
		V_DROPPED = 3'd2,
		V_UNKNOWN = 3'd3,
		V_FULL = 3'd4
	} verdict_t;

	localparam logic [1:0] PORT_OUTBOUND = 2'd0;
	localparam logic [1:0] PORT_INBOUND = 2'd1;

	// one flow table entry
	typedef struct packed {
		logic [31:0] sa;
		logic [31:0] da;
		logic [31:0] pp;
		logic [7:0] pr;
		logic [31:0] maddr;
		logic [15:0] mport;
	} entry_t;

	localparam int unsigned EW = $bits(entry_t);

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan_rd;
		logic capture;
		logic wr_own;
		logic wr_rev;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic untrans;
		logic scan_done;
		logic do_insert;
	} status_t;

endpackage

// File: rtl/core/nft_ram.sv
// generic single write port ram with registered read
// no dependencies
module nft_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/nft_ctrl.sv
// controller state machine of the nat flow translator
// depends on nft_pkg
module nft_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input nft_pkg::status_t status,
	output nft_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_WR_OWN,
		S_WR_REV,
		S_OUT
	} state_t;

	state_t state_q;
	logic out_valid_q;
	logic can_load;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign can_load = !out_valid_q || out_ready;

	// command decode
	always_comb begin
		cmd = '0;
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.scan_rd = (state_q == S_SCAN) && !status.scan_done && !status.untrans;
		cmd.capture = (state_q == S_DECIDE);
		cmd.wr_own = (state_q == S_WR_OWN);
		cmd.wr_rev = (state_q == S_WR_REV);
		cmd.out_load = (state_q == S_OUT) && can_load;
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (status.untrans || status.scan_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= status.do_insert ? S_WR_OWN : S_OUT;
				end
				S_WR_OWN: state_q <= S_WR_REV;
				S_WR_REV: state_q <= S_OUT;
				S_OUT: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/nft_datapath.sv
// datapath: request registers, flow table scan, inserts and result registers
// depends on nft_pkg and nft_ram
module nft_datapath (
	input logic clk,
	input logic arst_n,
	input nft_pkg::cmd_t cmd,
	output nft_pkg::status_t status,
	input logic [31:0] wan_ip,
	input logic in_pass,
	input logic [1:0] in_port,
	input logic ext_pass,
	input logic [1:0] ext_port,
	input logic from_outside,
	input logic [7:0] protocol,
	input logic first_fragment,
	input logic [15:0] l4_length,
	input logic [31:0] src_ip,
	input logic [31:0] dst_ip,
	input logic [15:0] src_port,
	input logic [15:0] dst_port,
	output logic [2:0] verdict,
	output logic [1:0] out_port,
	output logic [31:0] new_src_ip,
	output logic [31:0] new_dst_ip,
	output logic [15:0] new_src_port,
	output logic [15:0] new_dst_port,
	output logic route_hint_valid
);

	localparam logic [nft_pkg::CW-1:0] CNT_MAX = nft_pkg::CW'(nft_pkg::TABLE_ENTRIES);
	localparam logic [nft_pkg::CW-1:0] CNT_ONE = nft_pkg::CW'(1);

	// request registers
	logic outside_q;
	logic [7:0] proto_q;
	logic first_q;
	logic [15:0] tlen_q;
	logic [31:0] sip_q, dip_q;
	logic [15:0] sport_q, dport_q;

	// table control
	logic [nft_pkg::CW-1:0] count_q;
	logic [nft_pkg::CW-1:0] idx_q;
	logic [nft_pkg::AW-1:0] idx_s1;
	logic rd_valid_s1;
	logic fwd_hit_q, rev_hit_q;
	logic [31:0] fwd_addr_q;
	logic [15:0] fwd_port_q;
	logic [nft_pkg::AW-1:0] rev_idx_q, own_slot_q;

	// result registers
	logic [2:0] res_verdict_q;
	logic [1:0] res_port_q;
	logic [31:0] res_sip_q, res_dip_q;
	logic [15:0] res_sport_q, res_dport_q;
	logic res_hint_q;

	nft_pkg::entry_t rdata, wdata, own_key, rev_key;
	logic [nft_pkg::EW-1:0] rdata_raw;
	logic [nft_pkg::AW-1:0] waddr;
	logic we;
	logic proto_ok, untrans, same, need2, full, rev_new;

	// key forms of the held request
	always_comb begin
		own_key.sa = sip_q;
		own_key.da = dip_q;
		own_key.pp = {sport_q, dport_q};
		own_key.pr = proto_q;
		own_key.maddr = wan_ip;
		own_key.mport = sport_q;
		rev_key.sa = dip_q;
		rev_key.da = wan_ip;
		rev_key.pp = {dport_q, sport_q};
		rev_key.pr = proto_q;
		rev_key.maddr = sip_q;
		rev_key.mport = sport_q;
	end

	// classification
	assign proto_ok = (proto_q == nft_pkg::PROTO_TCP) || (proto_q == nft_pkg::PROTO_UDP)
		|| (proto_q == nft_pkg::PROTO_DCCP);
	assign untrans = !proto_ok || !first_q || (tlen_q < nft_pkg::MIN_TRANSPORT_LEN);
	assign same = (dip_q == sip_q) && (wan_ip == dip_q) && (dport_q == sport_q);
	assign need2 = !same && !rev_hit_q;
	assign rev_new = need2;
	assign full = (count_q == CNT_MAX) || (need2 && (count_q == CNT_MAX - CNT_ONE));

	assign status.untrans = untrans;
	assign status.scan_done = (idx_q == count_q);
	assign status.do_insert = !untrans && !outside_q && !fwd_hit_q && !full;

	// table memory
	assign we = cmd.wr_own || cmd.wr_rev;
	assign wdata = cmd.wr_own ? own_key : rev_key;
	always_comb begin
		if (cmd.wr_own || rev_new) begin
			waddr = count_q[nft_pkg::AW-1:0];
		end else if (same) begin
			waddr = own_slot_q;
		end else begin
			waddr = rev_idx_q;
		end
	end

	nft_ram #(
		.WIDTH(nft_pkg::EW),
		.DEPTH(nft_pkg::TABLE_ENTRIES)
	) u_table (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(cmd.scan_rd),
		.raddr(idx_q[nft_pkg::AW-1:0]),
		.rdata(rdata_raw)
	);
	assign rdata = nft_pkg::entry_t'(rdata_raw);

	// hold the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			outside_q <= from_outside;
			proto_q <= protocol;
			first_q <= first_fragment;
			tlen_q <= l4_length;
			sip_q <= src_ip;
			dip_q <= dst_ip;
			sport_q <= src_port;
			dport_q <= dst_port;
		end
	end

	// fill count and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q <= '0;
			rd_valid_s1 <= 1'b0;
			fwd_hit_q <= 1'b0;
			rev_hit_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				idx_q <= '0;
				fwd_hit_q <= 1'b0;
				rev_hit_q <= 1'b0;
			end else begin
				if (cmd.scan_rd) begin
					idx_q <= idx_q + CNT_ONE;
				end
				// compare both keys against the entry just read
				if (rd_valid_s1) begin
					if (rdata.sa == own_key.sa && rdata.da == own_key.da
						&& rdata.pp == own_key.pp && rdata.pr == own_key.pr) begin
						fwd_hit_q <= 1'b1;
					end
					if (rdata.sa == rev_key.sa && rdata.da == rev_key.da
						&& rdata.pp == rev_key.pp && rdata.pr == rev_key.pr) begin
						rev_hit_q <= 1'b1;
					end
				end
			end
			if (cmd.wr_own || (cmd.wr_rev && rev_new)) begin
				count_q <= count_q + CNT_ONE;
			end
		end
	end

	// payload of scan hits
	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			idx_s1 <= idx_q[nft_pkg::AW-1:0];
		end
		if (rd_valid_s1) begin
			if (rdata.sa == own_key.sa && rdata.da == own_key.da
				&& rdata.pp == own_key.pp && rdata.pr == own_key.pr) begin
				fwd_addr_q <= rdata.maddr;
				fwd_port_q <= rdata.mport;
			end
			if (rdata.sa == rev_key.sa && rdata.da == rev_key.da
				&& rdata.pp == rev_key.pp && rdata.pr == rev_key.pr) begin
				rev_idx_q <= idx_s1;
			end
		end
		if (cmd.wr_own) begin
			own_slot_q <= count_q[nft_pkg::AW-1:0];
		end
	end

	// verdict and rewritten header
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_port_q <= nft_pkg::PORT_OUTBOUND;
			res_sip_q <= sip_q;
			res_dip_q <= dip_q;
			res_sport_q <= sport_q;
			res_dport_q <= dport_q;
			res_hint_q <= 1'b0;
			if (untrans) begin
				if (outside_q ? ext_pass : in_pass) begin
					res_verdict_q <= nft_pkg::V_PASSED;
					res_port_q <= outside_q ? ext_port : in_port;
				end else begin
					res_verdict_q <= nft_pkg::V_DROPPED;
				end
			end else if (!outside_q) begin
				if (fwd_hit_q) begin
					res_verdict_q <= nft_pkg::V_TRANSLATED;
					res_sip_q <= fwd_addr_q;
					res_sport_q <= fwd_port_q;
				end else if (full) begin
					res_verdict_q <= nft_pkg::V_FULL;
				end else begin
					res_verdict_q <= nft_pkg::V_TRANSLATED;
					res_sip_q <= wan_ip;
				end
			end else begin
				if (fwd_hit_q) begin
					res_verdict_q <= nft_pkg::V_TRANSLATED;
					res_port_q <= nft_pkg::PORT_INBOUND;
					res_hint_q <= 1'b1;
					res_dip_q <= fwd_addr_q;
					res_dport_q <= fwd_port_q;
				end else begin
					res_verdict_q <= nft_pkg::V_UNKNOWN;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			verdict <= res_verdict_q;
			out_port <= res_port_q;
			new_src_ip <= res_sip_q;
			new_dst_ip <= res_dip_q;
			new_src_port <= res_sport_q;
			new_dst_port <= res_dport_q;
			route_hint_valid <= res_hint_q;
		end
	end

endmodule

// File: rtl/core/nat_flow_translator.sv
// top level of the nat flow translator: register port and instances
// depends on nft_pkg, nft_ctrl, nft_datapath, nft_ram
//
// Each request is one parsed ipv4 header on the input channel (in_valid,
// in_ready); one result per request leaves on the output channel
// (out_valid, out_ready). The flow table is filled in order from slot 0
// and searched linearly, one entry per cycle through the single read port
// of the table ram, comparing the forward and reverse keys together.
// After acceptance a request passes the states scan, decide, the own and
// reverse table writes (a new flow only) and out; the scan reads every
// entry in use unless the request is untranslatable. The next request is
// taken once the result has moved into the output register.
// One request is in work at a time; in_ready is high only when idle.
// A finished result sits in the output register; while the receiver stalls
// it holds, the next request can still be taken and searched, and it waits
// at the end for the output register to free up.
// Reset empties the table (fill count to zero, no clearing pass) and
// restores the registers: wan_ip 192.168.3.1, pass flags and ports 0.
// Registers at byte addresses 0,4,8,12,16: wan_ip, inside_other_pass,
// inside_other_port, outside_other_pass, outside_other_port.
module nat_flow_translator (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_ready,
	input logic from_outside,
	input logic [7:0] protocol,
	input logic first_fragment,
	input logic [15:0] l4_length,
	input logic [31:0] src_ip,
	input logic [31:0] dst_ip,
	input logic [15:0] src_port,
	input logic [15:0] dst_port,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] verdict,
	output logic [1:0] out_port,
	output logic [31:0] new_src_ip,
	output logic [31:0] new_dst_ip,
	output logic [15:0] new_src_port,
	output logic [15:0] new_dst_port,
	output logic route_hint_valid
);

	logic [31:0] wan_ip_q;
	logic in_pass_q, ext_pass_q;
	logic [1:0] in_port_q, ext_port_q;
	logic wr_en;
	nft_pkg::cmd_t cmd;
	nft_pkg::status_t status;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wan_ip_q <= nft_pkg::WAN_IP_RESET;
			in_pass_q <= 1'b0;
			in_port_q <= 2'd0;
			ext_pass_q <= 1'b0;
			ext_port_q <= 2'd0;
		end else if (wr_en) begin
			case (paddr)
				nft_pkg::ADDR_WAN_IP: wan_ip_q <= pwdata;
				nft_pkg::ADDR_IN_PASS: in_pass_q <= pwdata[0];
				nft_pkg::ADDR_IN_PORT: in_port_q <= pwdata[1:0];
				nft_pkg::ADDR_OUT_PASS: ext_pass_q <= pwdata[0];
				nft_pkg::ADDR_OUT_PORT: ext_port_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr)
			nft_pkg::ADDR_WAN_IP: prdata = wan_ip_q;
			nft_pkg::ADDR_IN_PASS: prdata = {31'd0, in_pass_q};
			nft_pkg::ADDR_IN_PORT: prdata = {30'd0, in_port_q};
			nft_pkg::ADDR_OUT_PASS: prdata = {31'd0, ext_pass_q};
			nft_pkg::ADDR_OUT_PORT: prdata = {30'd0, ext_port_q};
			default: prdata = 32'd0;
		endcase
	end

	nft_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.cmd(cmd)
	);

	nft_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.wan_ip(wan_ip_q),
		.in_pass(in_pass_q),
		.in_port(in_port_q),
		.ext_pass(ext_pass_q),
		.ext_port(ext_port_q),
		.from_outside(from_outside),
		.protocol(protocol),
		.first_fragment(first_fragment),
		.l4_length(l4_length),
		.src_ip(src_ip),
		.dst_ip(dst_ip),
		.src_port(src_port),
		.dst_port(dst_port),
		.verdict(verdict),
		.out_port(out_port),
		.new_src_ip(new_src_ip),
		.new_dst_ip(new_dst_ip),
		.new_src_port(new_src_port),
		.new_dst_port(new_dst_port),
		.route_hint_valid(route_hint_valid)
	);

endmodule

// File: rtl/core/nft_checker.sv
// port level checks for the nat flow translator, bound to the top level
// depends on nft_pkg and nat_flow_translator
module nft_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] verdict,
	input logic [1:0] out_port,
	input logic route_hint_valid
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict))
		else $error("result changed while stalled");

	// one request in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// route hint only on inbound translation
	a_hint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && route_hint_valid |->
		verdict == nft_pkg::V_TRANSLATED && out_port == nft_pkg::PORT_INBOUND)
		else $error("route hint on wrong verdict");

	// drop verdicts go to port zero
	a_drop_port: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (verdict == nft_pkg::V_DROPPED || verdict == nft_pkg::V_UNKNOWN
		|| verdict == nft_pkg::V_FULL) |-> out_port == nft_pkg::PORT_OUTBOUND)
		else $error("drop verdict with nonzero port");

endmodule

bind nat_flow_translator nft_checker u_nft_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.verdict(verdict),
	.out_port(out_port),
	.route_hint_valid(route_hint_valid)
);
